/* rtl/websocket_frame_unmasker_top_assert.svh */
// assertion macros shared by the checker of the websocket frame unmasker
`ifndef WEBSOCKET_FRAME_UNMASKER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_UNMASKER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define WSFU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsfu check failed");

// next-cycle implication, clocked on clk, off during reset
`define WSFU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsfu check failed");

`endif

/* rtl/wsfu_pkg.sv */
// types and constants of the websocket frame unmasker
package wsfu_pkg;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;
	localparam logic [3:0] OP_TEXT     = 4'd1;
	localparam logic [3:0] OP_BINARY   = 4'd2;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;
	localparam logic [15:0] INDEX_MAX  = 16'hffff;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN7,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic        last_byte;
		logic        is_binary;
		logic        final_fragment;
	} result_t;

endpackage

/* rtl/wsfu_in_if.sv */
// input channel: one received byte per word
interface wsfu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, data_byte, frame_start, input ready);
	modport sink (input valid, data_byte, frame_start, output ready);
endinterface

/* rtl/wsfu_out_if.sv */
// output channel: one unmasked payload byte per word
interface wsfu_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic [15:0] byte_index;
	logic        last_byte;
	logic        is_binary;
	logic        final_fragment;

	modport source (output valid, payload_byte, byte_index, last_byte, is_binary,
		final_fragment, input ready);
	modport sink (input valid, payload_byte, byte_index, last_byte, is_binary,
		final_fragment, output ready);
endinterface

/* rtl/wsfu_parser.sv */
// header parser and payload unmasking state machine
module wsfu_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              frame_start,
	output logic              emit,
	output wsfu_pkg::result_t result
);

	wsfu_pkg::phase_t phase_q, phase_n;
	logic        fin_q, fin_n;
	logic [3:0]  opcode_q, opcode_n;
	logic        masked_q, masked_n;
	logic [3:0]  left_q, left_n;
	logic [63:0] len_q, len_n;
	logic [31:0] key_q, key_n;
	logic [15:0] idx_q, idx_n;
	logic        op_ok;
	logic        last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsfu_pkg::PH_IDLE;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			masked_q <= 1'b0;
			left_q   <= '0;
			len_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			fin_q    <= fin_n;
			opcode_q <= opcode_n;
			masked_q <= masked_n;
			left_q   <= left_n;
			len_q    <= len_n;
			key_q    <= key_n;
			idx_q    <= idx_n;
		end
	end

	assign op_ok = (opcode_q == wsfu_pkg::OP_TEXT) || (opcode_q == wsfu_pkg::OP_BINARY);
	// len_q counts down the bytes still due during the payload
	assign last  = (len_q == 64'd1);

	always_comb begin
		phase_n  = phase_q;
		fin_n    = fin_q;
		opcode_n = opcode_q;
		masked_n = masked_q;
		left_n   = left_q;
		len_n    = len_q;
		key_n    = key_q;
		idx_n    = idx_q;
		emit     = 1'b0;
		result.payload_byte   = data_byte ^ key_q[31:24];
		result.byte_index     = idx_q;
		result.last_byte      = last;
		result.is_binary      = (opcode_q == wsfu_pkg::OP_BINARY);
		result.final_fragment = fin_q;

		if (frame_start) begin
			fin_n    = data_byte[7];
			opcode_n = data_byte[3:0];
			phase_n  = wsfu_pkg::PH_LEN7;
		end else begin
			unique case (phase_q)
				wsfu_pkg::PH_LEN7: begin
					masked_n = data_byte[7];
					if (data_byte[6:0] == wsfu_pkg::LEN_CODE_16) begin
						len_n   = '0;
						left_n  = wsfu_pkg::EXT16_BYTES;
						phase_n = wsfu_pkg::PH_EXTLEN;
					end else if (data_byte[6:0] == wsfu_pkg::LEN_CODE_64) begin
						len_n   = '0;
						left_n  = wsfu_pkg::EXT64_BYTES;
						phase_n = wsfu_pkg::PH_EXTLEN;
					end else begin
						len_n = {57'd0, data_byte[6:0]};
						if (data_byte[7]) begin
							left_n  = wsfu_pkg::KEY_BYTES;
							key_n   = '0;
							phase_n = wsfu_pkg::PH_KEY;
						end else begin
							phase_n = wsfu_pkg::PH_DONE;
						end
					end
				end
				wsfu_pkg::PH_EXTLEN: begin
					len_n  = {len_q[55:0], data_byte};
					left_n = left_q - 4'd1;
					if (left_q == 4'd1) begin
						if (masked_q) begin
							left_n  = wsfu_pkg::KEY_BYTES;
							key_n   = '0;
							phase_n = wsfu_pkg::PH_KEY;
						end else begin
							phase_n = wsfu_pkg::PH_DONE;
						end
					end
				end
				wsfu_pkg::PH_KEY: begin
					key_n  = {key_q[23:0], data_byte};
					left_n = left_q - 4'd1;
					if (left_q == 4'd1) begin
						idx_n = '0;
						if (masked_q && (len_q != 64'd0) && op_ok) begin
							phase_n = wsfu_pkg::PH_PAYLOAD;
						end else begin
							phase_n = wsfu_pkg::PH_DONE;
						end
					end
				end
				wsfu_pkg::PH_PAYLOAD: begin
					emit  = 1'b1;
					// rotate so the next key byte sits on top
					key_n = {key_q[23:0], key_q[31:24]};
					len_n = len_q - 64'd1;
					if (idx_q != wsfu_pkg::INDEX_MAX) begin
						idx_n = idx_q + 16'd1;
					end
					if (last) begin
						phase_n = wsfu_pkg::PH_DONE;
					end
				end
				wsfu_pkg::PH_IDLE, wsfu_pkg::PH_DONE: begin
				end
				default: begin
					phase_n = wsfu_pkg::PH_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/websocket_frame_unmasker_top.sv */
// top level of the websocket frame unmasker: input stage, parser, output register
//
// usage
// - stream carries one received byte per word; frame_start marks the first
//   header byte of a frame and always restarts parsing, dropping any frame
//   in progress
// - result carries one unmasked payload byte per word, with its index in the
//   payload (saturating at 65535), a last-byte mark, the text/binary flag and
//   the FIN bit; only masked text or binary frames with a nonzero length
//   produce words, header bytes and everything else produce none
// - path: a payload byte is registered in the input stage and then in the output register before it shows on result
// - throughput: one byte per cycle while result is not held, set by the single parser step per byte
//   between the input stage and the output register
// - reset: arst_n clears both stages and puts the parser back to waiting for
//   a frame start; bytes before the first frame start are dropped
// - stall: while result is held, the output register keeps its word and the
//   input stage takes one more byte only if it is empty, then stream.ready drops
//   until the output register is taken
module websocket_frame_unmasker_top (
	input  logic       clk,
	input  logic       arst_n,
	wsfu_in_if.sink    stream,
	wsfu_out_if.source result
);

	// input stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;

	// output register
	logic              out_valid_q;
	wsfu_pkg::result_t out_q;

	logic              advance;
	logic              emit;
	wsfu_pkg::result_t res;

	// the input stage moves on when the output register is free or being taken
	assign advance      = !out_valid_q || result.ready;
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	// payload of the input stage needs no reset
	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			data_s1  <= stream.data_byte;
			start_s1 <= stream.frame_start;
		end
	end

	wsfu_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (valid_s1 && advance),
		.data_byte   (data_s1),
		.frame_start (start_s1),
		.emit        (emit),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_q <= res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.payload_byte   = out_q.payload_byte;
	assign result.byte_index     = out_q.byte_index;
	assign result.last_byte      = out_q.last_byte;
	assign result.is_binary      = out_q.is_binary;
	assign result.final_fragment = out_q.final_fragment;

endmodule

/* rtl/wsfu_checker.sv */
// port-level checker of the websocket frame unmasker, bound to the top level
`include "websocket_frame_unmasker_top_assert.svh"

module wsfu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_frame_start,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_payload_byte,
	input logic        out_last_byte
);

	// a held result keeps its word
	`WSFU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload_byte))

	// input backpressure only comes from a stalled result
	`WSFU_ASSERT_NOW(a_ready_cause, !in_ready, out_valid && !out_ready)

	// after the last byte of a frame, a new header must come first
	`WSFU_ASSERT_NEXT(a_gap_after_last, out_valid && out_ready && out_last_byte, !out_valid)

	// a frame start byte never raises out_valid as it passes from the input stage to the output register
	`WSFU_ASSERT_NOW(a_start_silent, in_valid && in_ready && in_frame_start, ##2 !$rose(out_valid))

endmodule

bind websocket_frame_unmasker_top wsfu_checker u_wsfu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (stream.valid),
	.in_ready         (stream.ready),
	.in_frame_start   (stream.frame_start),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.out_payload_byte (result.payload_byte),
	.out_last_byte    (result.last_byte)
);
